>>> src/fovc_pkg.sv
package fovc_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int RATIO_FRAC    = 24;
  localparam int QW            = 31;
  localparam int ATAN_STEPS    = 30;
  localparam int CFG_IDX_W     = 3;

  localparam logic [QW-1:0] SAT_MAG = '1;
  localparam logic signed [31:0] PIX_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] PIX_MIN = 32'sh8000_0000;

  localparam logic [CFG_IDX_W-1:0] REG_ROW0   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW1   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ROW2   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_INTR   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LENS   = 3'd5;

  localparam logic [1:0] ST_FRONT  = 2'd0;
  localparam logic [1:0] ST_BEHIND = 2'd1;
  localparam logic [1:0] ST_ZERO   = 2'd2;

  typedef enum logic [1:0] {
    OVR_NONE = 2'd0,
    OVR_POS  = 2'd1,
    OVR_NEG  = 2'd2
  } ovr_t;

  typedef struct packed {
    logic       xneg;
    logic       yneg;
    logic [1:0] status;
    ovr_t       ovr_u;
    ovr_t       ovr_v;
  } fovc_flag_t;

  typedef struct packed {
    fovc_flag_t    flag;
    logic          warp;
    logic [QW-1:0] xm;
    logic [QW-1:0] ym;
  } fovc_pt_t;

  function automatic logic [31:0] atan_entry(input logic [4:0] idx);
    logic [31:0] e;
    case (idx)
      5'd0:  e = 32'h3243F6A8;
      5'd1:  e = 32'h1DAC6705;
      5'd2:  e = 32'h0FADBAFC;
      5'd3:  e = 32'h07F56EA6;
      5'd4:  e = 32'h03FEAB76;
      5'd5:  e = 32'h01FFD55B;
      5'd6:  e = 32'h00FFFAAA;
      5'd7:  e = 32'h007FFF55;
      5'd8:  e = 32'h003FFFEA;
      5'd9:  e = 32'h001FFFFD;
      5'd10: e = 32'h000FFFFF;
      5'd11: e = 32'h0007FFFF;
      5'd12: e = 32'h0003FFFF;
      5'd13: e = 32'h0001FFFF;
      5'd14: e = 32'h0000FFFF;
      5'd15: e = 32'h00007FFF;
      5'd16: e = 32'h00003FFF;
      5'd17: e = 32'h00001FFF;
      5'd18: e = 32'h00000FFF;
      5'd19: e = 32'h000007FF;
      5'd20: e = 32'h000003FF;
      5'd21: e = 32'h000001FF;
      5'd22: e = 32'h000000FF;
      5'd23: e = 32'h0000007F;
      5'd24: e = 32'h0000003F;
      5'd25: e = 32'h0000001F;
      5'd26: e = 32'h0000000F;
      5'd27: e = 32'h00000007;
      5'd28: e = 32'h00000003;
      5'd29: e = 32'h00000001;
      default: e = 32'h00000000;
    endcase
    return e;
  endfunction

endpackage

>>> src/fovc_udiv.sv
module fovc_udiv
  import fovc_pkg::*;
#(
  parameter int NUMW = 52,
  parameter int DENW = 52,
  parameter int FB   = 16,
  parameter int NL   = 2,
  parameter int SBW  = 8
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     en,
  input  logic                     in_vld,
  input  logic [NL-1:0][NUMW-1:0]  in_num,
  input  logic [DENW-1:0]          in_den,
  input  logic [SBW-1:0]           in_sb,
  output logic                     out_vld,
  output logic [NL-1:0][QW-1:0]    out_quo,
  output logic [SBW-1:0]           out_sb
);

  localparam int FW = NUMW + FB;
  localparam int IW = FW - QW;
  localparam int CW = (IW > DENW) ? IW : DENW;

  logic                     v_r   [0:QW];
  logic [SBW-1:0]           sb_r  [0:QW];
  logic [DENW-1:0]          den_r [0:QW];
  logic [NL-1:0]            sat_r [0:QW];
  logic [NL-1:0][DENW-1:0]  rem_r [0:QW];
  logic [NL-1:0][QW-1:0]    quo_r [0:QW];
  logic [NL-1:0][QW-1:0]    lo_r  [0:QW];

  logic [NL-1:0][DENW-1:0]  rem0_nxt;
  logic [NL-1:0]            sat0_nxt;
  logic [NL-1:0][QW-1:0]    lo0_nxt;

  always_comb begin
    logic [FW-1:0] full;
    logic [CW-1:0] init_ext;
    full     = '0;
    init_ext = '0;
    for (int l = 0; l < NL; l++) begin
      full        = {in_num[l], {FB{1'b0}}};
      init_ext    = CW'(full[FW-1:QW]);
      sat0_nxt[l] = init_ext >= CW'(in_den);
      rem0_nxt[l] = DENW'(init_ext);
      lo0_nxt[l]  = full[QW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_vld;
    end
    if (en) begin
      sb_r[0]  <= in_sb;
      den_r[0] <= in_den;
      sat_r[0] <= sat0_nxt;
      rem_r[0] <= rem0_nxt;
      quo_r[0] <= '0;
      lo_r[0]  <= lo0_nxt;
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_step
    logic [NL-1:0][DENW-1:0] rem_nxt;
    logic [NL-1:0][QW-1:0]   quo_nxt;
    logic [NL-1:0][QW-1:0]   lo_nxt;

    always_comb begin
      logic [DENW:0] t;
      logic [DENW:0] dd;
      t  = '0;
      dd = {1'b0, den_r[k-1]};
      for (int l = 0; l < NL; l++) begin
        t = {rem_r[k-1][l], lo_r[k-1][l][QW-1]};
        if (t >= dd) begin
          rem_nxt[l] = DENW'(t - dd);
          quo_nxt[l] = {quo_r[k-1][l][QW-2:0], 1'b1};
        end else begin
          rem_nxt[l] = t[DENW-1:0];
          quo_nxt[l] = {quo_r[k-1][l][QW-2:0], 1'b0};
        end
        lo_nxt[l] = {lo_r[k-1][l][QW-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_r[k-1];
      end
      if (en) begin
        sb_r[k]  <= sb_r[k-1];
        den_r[k] <= den_r[k-1];
        sat_r[k] <= sat_r[k-1];
        rem_r[k] <= rem_nxt;
        quo_r[k] <= quo_nxt;
        lo_r[k]  <= lo_nxt;
      end
    end
  end

  always_comb begin
    for (int l = 0; l < NL; l++) begin
      out_quo[l] = sat_r[QW][l] ? SAT_MAG : quo_r[QW][l];
    end
  end

  assign out_vld = v_r[QW];
  assign out_sb  = sb_r[QW];

endmodule

>>> src/fovc_isqrt.sv
module fovc_isqrt #(
  parameter int SBW = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_vld,
  input  logic [63:0]    in_val,
  input  logic [SBW-1:0] in_sb,
  output logic           out_vld,
  output logic [31:0]    out_root,
  output logic [SBW-1:0] out_sb
);

  localparam int RW = 32;
  localparam int VW = 2 * RW;
  localparam int MW = RW + 2;

  logic           v_r    [0:RW];
  logic [SBW-1:0] sb_r   [0:RW];
  logic [VW-1:0]  val_r  [0:RW];
  logic [MW-1:0]  rem_r  [0:RW];
  logic [RW-1:0]  root_r [0:RW];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_vld;
    end
    if (en) begin
      sb_r[0]   <= in_sb;
      val_r[0]  <= in_val;
      rem_r[0]  <= '0;
      root_r[0] <= '0;
    end
  end

  for (genvar k = 1; k <= RW; k++) begin : g_step
    logic [MW-1:0] rem_nxt;
    logic [RW-1:0] root_nxt;
    logic [VW-1:0] val_nxt;

    always_comb begin
      logic [MW+1:0] t;
      logic [MW+1:0] trial;
      t     = {rem_r[k-1], val_r[k-1][VW-1:VW-2]};
      trial = {2'b00, root_r[k-1], 2'b01};
      if (t >= trial) begin
        rem_nxt  = MW'(t - trial);
        root_nxt = {root_r[k-1][RW-2:0], 1'b1};
      end else begin
        rem_nxt  = t[MW-1:0];
        root_nxt = {root_r[k-1][RW-2:0], 1'b0};
      end
      val_nxt = {val_r[k-1][VW-3:0], 2'b00};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_r[k-1];
      end
      if (en) begin
        sb_r[k]   <= sb_r[k-1];
        val_r[k]  <= val_nxt;
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
      end
    end
  end

  assign out_vld  = v_r[RW];
  assign out_root = root_r[RW];
  assign out_sb   = sb_r[RW];

endmodule

>>> src/fovc_cordic.sv
module fovc_cordic
  import fovc_pkg::*;
#(
  parameter int FB  = 16,
  parameter int SBW = 8
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           en,
  input  logic           in_vld,
  input  logic [47:0]    in_a,
  input  logic [SBW-1:0] in_sb,
  output logic           out_vld,
  output logic [31:0]    out_theta,
  output logic [SBW-1:0] out_sb
);

  localparam int XW = 52;
  localparam int GW = 34;
  localparam int N  = ATAN_STEPS;

  logic                 v_r   [0:N];
  logic [SBW-1:0]       sb_r  [0:N];
  logic signed [XW-1:0] x_r   [0:N];
  logic signed [XW-1:0] y_r   [0:N];
  logic signed [GW-1:0] ang_r [0:N];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en) begin
      v_r[0] <= in_vld;
    end
    if (en) begin
      sb_r[0]  <= in_sb;
      x_r[0]   <= $signed({{(XW-1){1'b0}}, 1'b1} << (FB + 12));
      y_r[0]   <= $signed(XW'(in_a));
      ang_r[0] <= '0;
    end
  end

  for (genvar k = 1; k <= N; k++) begin : g_iter
    logic signed [XW-1:0] x_nxt;
    logic signed [XW-1:0] y_nxt;
    logic signed [GW-1:0] ang_nxt;

    always_comb begin
      logic signed [XW-1:0] dx;
      logic signed [XW-1:0] dy;
      logic signed [GW-1:0] tab;
      dx  = x_r[k-1] >>> (k - 1);
      dy  = y_r[k-1] >>> (k - 1);
      tab = $signed({2'b00, atan_entry(5'(k - 1))});
      if (!y_r[k-1][XW-1]) begin
        x_nxt   = x_r[k-1] + dy;
        y_nxt   = y_r[k-1] - dx;
        ang_nxt = ang_r[k-1] + tab;
      end else begin
        x_nxt   = x_r[k-1] - dy;
        y_nxt   = y_r[k-1] + dx;
        ang_nxt = ang_r[k-1] - tab;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= v_r[k-1];
      end
      if (en) begin
        sb_r[k]  <= sb_r[k-1];
        x_r[k]   <= x_nxt;
        y_r[k]   <= y_nxt;
        ang_r[k] <= ang_nxt;
      end
    end
  end

  assign out_vld   = v_r[N];
  assign out_theta = ang_r[N][GW-1] ? 32'd0 : ang_r[N][31:0];
  assign out_sb    = sb_r[N];

endmodule

>>> src/fovc_pixel.sv
module fovc_pixel
  import fovc_pkg::*;
#(
  parameter int FB = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_vld,
  input  fovc_pt_t           in_pt,
  input  logic [QW-1:0]      in_ratio,
  input  logic [15:0]        fx,
  input  logic [15:0]        fy,
  input  logic [15:0]        cx,
  input  logic [15:0]        cy,
  output logic               out_vld,
  output logic signed [31:0] out_u,
  output logic signed [31:0] out_v,
  output logic [1:0]         out_status
);

  localparam int PW  = 2 * QW;
  localparam int SHW = PW - RATIO_FRAC;
  localparam int MPW = 49;
  localparam int AW  = 50;

  logic            p1_v_r, p2_v_r, p3_v_r, p4_v_r;
  fovc_pt_t        p1_pt_r, p2_pt_r, p3_pt_r;
  logic [PW-1:0]   p1_px_r, p1_py_r;
  logic [PW-1:0]   p1_px_nxt, p1_py_nxt;
  logic signed [31:0] p2_dx_r, p2_dy_r, p2_dx_nxt, p2_dy_nxt;
  logic signed [MPW-1:0] p3_pu_r, p3_pv_r, p3_pu_nxt, p3_pv_nxt;
  logic signed [31:0] p4_u_r, p4_vpix_r, p4_u_nxt, p4_vpix_nxt;
  logic [1:0]      p4_st_r;

  assign p1_px_nxt = in_pt.xm * in_ratio;
  assign p1_py_nxt = in_pt.ym * in_ratio;

  function automatic logic signed [31:0] scale_sign(input logic [PW-1:0] prod,
                                                    input logic [QW-1:0] m,
                                                    input logic warp,
                                                    input logic neg);
    logic [SHW-1:0] sh;
    logic [QW-1:0]  mag;
    sh  = prod[PW-1:RATIO_FRAC];
    mag = m;
    if (warp) begin
      mag = (sh > SHW'(SAT_MAG)) ? SAT_MAG : sh[QW-1:0];
    end
    return neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
  endfunction

  function automatic logic signed [31:0] add_sat(input logic signed [MPW-1:0] pr,
                                                 input logic [15:0] c);
    logic signed [AW-1:0] acc;
    logic signed [AW-1:0] sh;
    logic [AW-1:0]        cterm;
    logic [AW-32:0]       hi;
    logic signed [31:0]   res;
    cterm = AW'(c) << FB;
    acc   = AW'(pr) + $signed(cterm);
    sh    = acc >>> 4;
    hi    = sh[AW-1:31];
    if (&hi || ~|hi) begin
      res = sh[31:0];
    end else begin
      res = sh[AW-1] ? PIX_MIN : PIX_MAX;
    end
    return res;
  endfunction

  function automatic logic signed [31:0] apply_ovr(input ovr_t o, input logic signed [31:0] d);
    logic signed [31:0] r;
    case (o)
      OVR_POS: r = PIX_MAX;
      OVR_NEG: r = PIX_MIN;
      default: r = d;
    endcase
    return r;
  endfunction

  assign p2_dx_nxt   = scale_sign(p1_px_r, p1_pt_r.xm, p1_pt_r.warp, p1_pt_r.flag.xneg);
  assign p2_dy_nxt   = scale_sign(p1_py_r, p1_pt_r.ym, p1_pt_r.warp, p1_pt_r.flag.yneg);
  assign p3_pu_nxt   = $signed({1'b0, fx}) * p2_dx_r;
  assign p3_pv_nxt   = $signed({1'b0, fy}) * p2_dy_r;
  assign p4_u_nxt    = apply_ovr(p3_pt_r.flag.ovr_u, add_sat(p3_pu_r, cx));
  assign p4_vpix_nxt = apply_ovr(p3_pt_r.flag.ovr_v, add_sat(p3_pv_r, cy));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_v_r <= 1'b0;
      p2_v_r <= 1'b0;
      p3_v_r <= 1'b0;
      p4_v_r <= 1'b0;
    end else if (en) begin
      p1_v_r <= in_vld;
      p2_v_r <= p1_v_r;
      p3_v_r <= p2_v_r;
      p4_v_r <= p3_v_r;
    end
    if (en) begin
      p1_pt_r   <= in_pt;
      p1_px_r   <= p1_px_nxt;
      p1_py_r   <= p1_py_nxt;
      p2_pt_r   <= p1_pt_r;
      p2_dx_r   <= p2_dx_nxt;
      p2_dy_r   <= p2_dy_nxt;
      p3_pt_r   <= p2_pt_r;
      p3_pu_r   <= p3_pu_nxt;
      p3_pv_r   <= p3_pv_nxt;
      p4_u_r    <= p4_u_nxt;
      p4_vpix_r <= p4_vpix_nxt;
      p4_st_r   <= p3_pt_r.flag.status;
    end
  end

  assign out_vld    = p4_v_r;
  assign out_u      = p4_u_r;
  assign out_v      = p4_vpix_r;
  assign out_status = p4_st_r;

endmodule

>>> src/fov_camera_project_point.sv
// Throughput: one point per cycle; every stage advances together and a two-entry
// output queue takes results, so input stalls only when that queue is full and stalled.
// Depth is set by the two 31-step dividers, the 32-step square root and 30-step CORDIC.
// Reset (synchronous, rst_n low): clears all valid bits and the queue, loads identity
// rotation and zero offset, intrinsics and lens registers.
module fov_camera_project_point
  import fovc_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic signed [31:0]   in_world_x,
  input  logic signed [31:0]   in_world_y,
  input  logic signed [31:0]   in_world_z,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic signed [31:0]   out_pixel_u,
  output logic signed [31:0]   out_pixel_v,
  output logic [1:0]           out_status,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_data
);

  localparam int PW = 34;
  localparam int MW = 50;
  localparam int CW = 52;

  typedef struct packed {
    logic signed [31:0] u;
    logic signed [31:0] v;
    logic [1:0]         status;
  } res_t;

  logic [47:0] row_r [0:2];
  logic [47:0] off_r;
  logic [63:0] intr_r;
  logic [31:0] lens_r;

  logic adv;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r[0] <= 48'h0000_0000_4000;
      row_r[1] <= 48'h0000_4000_0000;
      row_r[2] <= 48'h4000_0000_0000;
      off_r    <= '0;
      intr_r   <= '0;
      lens_r   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_ROW0:   row_r[0] <= cfg_data[47:0];
        REG_ROW1:   row_r[1] <= cfg_data[47:0];
        REG_ROW2:   row_r[2] <= cfg_data[47:0];
        REG_OFFSET: off_r    <= cfg_data[47:0];
        REG_INTR:   intr_r   <= cfg_data;
        REG_LENS:   lens_r   <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  // translate, rotate, take magnitudes
  logic signed [31:0]   world [0:2];
  logic                 s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic signed [PW-1:0] s1_p_r [0:2], s1_p_nxt [0:2];
  logic signed [MW-1:0] s2_m_r [0:2][0:2], s2_m_nxt [0:2][0:2];
  logic signed [CW-1:0] s3_c_r [0:2], s3_c_nxt [0:2];
  logic [1:0][CW-1:0]   s4_num_r, s4_num_nxt;
  logic [CW-1:0]        s4_den_r, s4_den_nxt;
  fovc_flag_t           s4_flag_r, s4_flag_nxt;

  assign world[0] = in_world_x;
  assign world[1] = in_world_y;
  assign world[2] = in_world_z;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      s1_p_nxt[i] = PW'(world[i])
                  + (PW'($signed(off_r[16*i +: 16])) <<< (FRAC_BITS - 8));
      s3_c_nxt[i] = CW'(s2_m_r[i][0]) + CW'(s2_m_r[i][1]) + CW'(s2_m_r[i][2]);
      for (int j = 0; j < 3; j++) begin
        s2_m_nxt[i][j] = $signed(row_r[i][16*j +: 16]) * s1_p_r[j];
      end
    end
  end

  function automatic logic [CW-1:0] mag(input logic signed [CW-1:0] c);
    return c[CW-1] ? CW'(-c) : CW'(c);
  endfunction

  function automatic ovr_t zero_ovr(input logic zd, input logic signed [CW-1:0] c);
    ovr_t o;
    o = OVR_NONE;
    if (zd && c[CW-1]) begin
      o = OVR_NEG;
    end else if (zd && c != '0) begin
      o = OVR_POS;
    end
    return o;
  endfunction

  always_comb begin
    logic zd;
    logic zneg;
    zd   = (s3_c_r[2] == '0);
    zneg = s3_c_r[2][CW-1];
    s4_flag_nxt.xneg   = s3_c_r[0][CW-1] != zneg;
    s4_flag_nxt.yneg   = s3_c_r[1][CW-1] != zneg;
    s4_flag_nxt.status = zd ? ST_ZERO : (zneg ? ST_BEHIND : ST_FRONT);
    s4_flag_nxt.ovr_u  = zero_ovr(zd, s3_c_r[0]);
    s4_flag_nxt.ovr_v  = zero_ovr(zd, s3_c_r[1]);
    s4_num_nxt[0]      = mag(s3_c_r[0]);
    s4_num_nxt[1]      = mag(s3_c_r[1]);
    s4_den_nxt         = mag(s3_c_r[2]);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else if (adv) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
    if (adv) begin
      s1_p_r    <= s1_p_nxt;
      s2_m_r    <= s2_m_nxt;
      s3_c_r    <= s3_c_nxt;
      s4_num_r  <= s4_num_nxt;
      s4_den_r  <= s4_den_nxt;
      s4_flag_r <= s4_flag_nxt;
    end
  end

  // perspective divide
  logic                 d1_vld;
  logic [1:0][QW-1:0]   d1_quo;
  fovc_flag_t           d1_flag;

  fovc_udiv #(
    .NUMW (CW),
    .DENW (CW),
    .FB   (FRAC_BITS),
    .NL   (2),
    .SBW  ($bits(fovc_flag_t))
  ) u_div_xy (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (s4_v_r),
    .in_num  (s4_num_r),
    .in_den  (s4_den_r),
    .in_sb   (s4_flag_r),
    .out_vld (d1_vld),
    .out_quo (d1_quo),
    .out_sb  (d1_flag)
  );

  // radius squared
  logic            s5_v_r, s6_v_r;
  fovc_pt_t        s5_pt_r, s5_pt_nxt, s6_pt_r;
  logic [2*QW-1:0] s5_sx_r, s5_sy_r, s5_sx_nxt, s5_sy_nxt;
  logic [63:0]     s6_sum_r, s6_sum_nxt;

  always_comb begin
    logic zd;
    zd             = (d1_flag.status == ST_ZERO);
    s5_pt_nxt.flag = d1_flag;
    s5_pt_nxt.warp = 1'b0;
    s5_pt_nxt.xm   = zd ? '0 : d1_quo[0];
    s5_pt_nxt.ym   = zd ? '0 : d1_quo[1];
  end

  assign s5_sx_nxt  = s5_pt_nxt.xm * s5_pt_nxt.xm;
  assign s5_sy_nxt  = s5_pt_nxt.ym * s5_pt_nxt.ym;
  assign s6_sum_nxt = 64'(s5_sx_r) + 64'(s5_sy_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
      s6_v_r <= 1'b0;
    end else if (adv) begin
      s5_v_r <= d1_vld;
      s6_v_r <= s5_v_r;
    end
    if (adv) begin
      s5_pt_r  <= s5_pt_nxt;
      s5_sx_r  <= s5_sx_nxt;
      s5_sy_r  <= s5_sy_nxt;
      s6_pt_r  <= s5_pt_r;
      s6_sum_r <= s6_sum_nxt;
    end
  end

  logic        sq_vld;
  logic [31:0] sq_ru;
  fovc_pt_t    sq_pt;

  fovc_isqrt #(
    .SBW ($bits(fovc_pt_t))
  ) u_isqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .in_vld   (s6_v_r),
    .in_val   (s6_sum_r),
    .in_sb    (s6_pt_r),
    .out_vld  (sq_vld),
    .out_root (sq_ru),
    .out_sb   (sq_pt)
  );

  // lens terms
  logic        s7_v_r;
  fovc_pt_t    s7_pt_r, s7_pt_nxt;
  logic [47:0] s7_a_r, s7_den_r, s7_a_nxt, s7_den_nxt;

  always_comb begin
    s7_pt_nxt      = sq_pt;
    s7_pt_nxt.warp = (sq_ru != '0) && (lens_r[15:0] != '0);
    s7_a_nxt       = sq_ru * lens_r[31:16];
    s7_den_nxt     = sq_ru * lens_r[15:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_v_r <= 1'b0;
    end else if (adv) begin
      s7_v_r <= sq_vld;
    end
    if (adv) begin
      s7_pt_r  <= s7_pt_nxt;
      s7_a_r   <= s7_a_nxt;
      s7_den_r <= s7_den_nxt;
    end
  end

  logic        co_vld;
  logic [31:0] co_theta;
  logic [47:0] co_den;
  fovc_pt_t    co_pt;

  fovc_cordic #(
    .FB  (FRAC_BITS),
    .SBW (48 + $bits(fovc_pt_t))
  ) u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (adv),
    .in_vld    (s7_v_r),
    .in_a      (s7_a_r),
    .in_sb     ({s7_den_r, s7_pt_r}),
    .out_vld   (co_vld),
    .out_theta (co_theta),
    .out_sb    ({co_den, co_pt})
  );

  // distortion ratio
  logic               d2_vld;
  logic [0:0][QW-1:0] d2_quo;
  fovc_pt_t           d2_pt;
  logic [0:0][31:0]   d2_num;

  assign d2_num[0] = co_theta;

  fovc_udiv #(
    .NUMW (32),
    .DENW (48),
    .FB   (FRAC_BITS + RATIO_FRAC - 16),
    .NL   (1),
    .SBW  ($bits(fovc_pt_t))
  ) u_div_ratio (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .in_vld  (co_vld),
    .in_num  (d2_num),
    .in_den  (co_den),
    .in_sb   (co_pt),
    .out_vld (d2_vld),
    .out_quo (d2_quo),
    .out_sb  (d2_pt)
  );

  logic               px_vld;
  logic signed [31:0] px_u, px_v;
  logic [1:0]         px_st;

  fovc_pixel #(
    .FB (FRAC_BITS)
  ) u_pixel (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (adv),
    .in_vld     (d2_vld),
    .in_pt      (d2_pt),
    .in_ratio   (d2_quo[0]),
    .fx         (intr_r[15:0]),
    .fy         (intr_r[31:16]),
    .cx         (intr_r[47:32]),
    .cy         (intr_r[63:48]),
    .out_vld    (px_vld),
    .out_u      (px_u),
    .out_v      (px_v),
    .out_status (px_st)
  );

  // output queue
  res_t       q_r [0:1];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r, cnt_nxt;
  logic       push, pop;

  assign adv      = (cnt_r != 2'd2) || !out_stall;
  assign in_stall = !adv;
  assign push     = adv && px_vld;
  assign pop      = out_valid && !out_stall;

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
    if (push) begin
      q_r[wr_ptr_r] <= '{u: px_u, v: px_v, status: px_st};
    end
  end

  assign out_valid   = cnt_r != 2'd0;
  assign out_pixel_u = q_r[rd_ptr_r].u;
  assign out_pixel_v = q_r[rd_ptr_r].v;
  assign out_status  = q_r[rd_ptr_r].status;

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (cnt_r == 2'd2 && out_stall))
    else $error("input stalled without a full, stalled output queue");

  a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && out_stall) |=> cnt_r == 2'd2)
    else $error("full queue changed while output stalled");

  a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd0 && push) |=> out_valid)
    else $error("result pushed to empty queue not presented");

endmodule
